[hw/rtl/cle_pkg.sv]
// Shared constants and types for the contiguous list engine.
`default_nettype none
package cle_pkg;
  localparam int Depth = 64;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = AddrW + 1;
  localparam int DataW = 32;

  localparam logic [3:0] FN_CLEAR    = 4'd0;
  localparam logic [3:0] FN_INS_FRST = 4'd1;
  localparam logic [3:0] FN_INS_LAST = 4'd2;
  localparam logic [3:0] FN_INS_AT   = 4'd3;
  localparam logic [3:0] FN_DEL_FRST = 4'd4;
  localparam logic [3:0] FN_DEL_LAST = 4'd5;
  localparam logic [3:0] FN_DEL_AT   = 4'd6;
  localparam logic [3:0] FN_GET      = 4'd7;
  localparam logic [3:0] FN_SET      = 4'd8;
  localparam logic [3:0] FN_SEARCH   = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADIDX   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
endpackage
`default_nettype wire

[hw/rtl/contiguous_list_engine.sv]
// Contiguous list engine: list block in a dual-port synchronous store plus a control sequencer.
`default_nettype none
// One operation per input beat, one result beat per operation. Clear, insert into free
// space, set and failing operations pass through decode and output; get and the end deletes
// also wait on a store read. Shifting inserts and delete at walk the moved part of the block
// one entry at a time through the store's read and write ports (read, then write); search
// reads one entry per cycle. Input stalls while an operation runs or its result waits;
// the result register holds until taken.
module contiguous_list_engine
  import cle_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [3:0]       func,
  input  wire logic [6:0]       position,
  input  wire logic signed [31:0] item_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            status,
  output logic signed [31:0]    read_value,
  output logic [5:0]            found_index,
  output logic [6:0]            length
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_MVRD = 3'd2;
  localparam logic [2:0] S_MVWR = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_SRCH = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata;
  logic             we;
  addr_t            waddr, raddr;
  logic [DataW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [2:0]       state;
  logic [3:0]       fn;
  cnt_t             pos;
  logic [DataW-1:0] val;
  addr_t            start_pos;
  cnt_t             count;
  addr_t            cur;      // next source entry in a walk
  addr_t            stop;     // last source entry of a walk
  logic             dir_r;    // 1: move toward higher entries
  addr_t            fin_addr; // final write of the inserted value
  logic             fin_wr;
  cnt_t             sidx;     // search: logical index of entry being read
  logic             srch_pend;
  logic             grab;     // capture rdata into read_value

  assign in_stall = (state != S_IDLE) || out_valid;

  // Derived values from registered state
  cnt_t  endp;
  addr_t tgt;
  assign endp = cnt_t'(start_pos) + count;
  assign tgt  = start_pos + pos[AddrW-1:0];

  always_comb begin
    raddr = cur;
    if (state == S_SRCH) raddr = start_pos + sidx[AddrW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start_pos <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      we        <= 1'b0;
    end else begin
      we <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            fn    <= func;
            pos   <= position;
            val   <= item_value;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          status      <= ST_OK;
          read_value  <= '0;
          found_index <= '0;
          fin_wr      <= 1'b0;
          grab        <= 1'b0;
          state       <= S_OUT;
          case (fn)
            FN_CLEAR: begin
              count <= '0; start_pos <= '0;
            end
            FN_INS_FRST, FN_INS_LAST, FN_INS_AT: begin
              if (count == cnt_t'(Depth)) status <= ST_FULL;
              else if (fn == FN_INS_AT && pos > count) status <= ST_BADIDX;
              else begin
                count <= count + 1'b1;
                if (count == '0) begin
                  start_pos <= '0;
                  we <= 1'b1; waddr <= '0; wdata <= val;
                end else if (fn == FN_INS_FRST && start_pos != '0) begin
                  start_pos <= start_pos - 1'b1;
                  we <= 1'b1; waddr <= start_pos - 1'b1; wdata <= val;
                end else if (fn == FN_INS_LAST && endp < cnt_t'(Depth)) begin
                  we <= 1'b1; waddr <= endp[AddrW-1:0]; wdata <= val;
                end else if (fn == FN_INS_AT && endp < cnt_t'(Depth)
                             && pos == count) begin
                  we <= 1'b1; waddr <= endp[AddrW-1:0]; wdata <= val;
                end else if (fn == FN_INS_LAST || (fn == FN_INS_AT
                             && endp == cnt_t'(Depth) && pos == count)) begin
                  // right edge full: move block left, append at top
                  start_pos <= start_pos - 1'b1;
                  dir_r <= 1'b0; cur <= start_pos; stop <= addr_t'(Depth - 1);
                  fin_addr <= addr_t'(Depth - 1); fin_wr <= 1'b1;
                  state <= S_MVRD;
                end else if (fn == FN_INS_FRST) begin
                  // start at 0: move block right
                  dir_r <= 1'b1; cur <= endp[AddrW-1:0] - 1'b1; stop <= '0;
                  fin_addr <= '0; fin_wr <= 1'b1;
                  state <= S_MVRD;
                end else if (endp < cnt_t'(Depth)) begin
                  dir_r <= 1'b1; cur <= endp[AddrW-1:0] - 1'b1; stop <= tgt;
                  fin_addr <= tgt; fin_wr <= 1'b1;
                  state <= S_MVRD;
                end else begin
                  start_pos <= start_pos - 1'b1;
                  fin_addr <= tgt - 1'b1; fin_wr <= 1'b1;
                  if (pos == '0) begin
                    we <= 1'b1; waddr <= tgt - 1'b1; wdata <= val;
                  end else begin
                    dir_r <= 1'b0; cur <= start_pos; stop <= tgt - 1'b1;
                    state <= S_MVRD;
                  end
                end
              end
            end
            FN_DEL_FRST, FN_DEL_LAST, FN_DEL_AT, FN_GET, FN_SET: begin
              if (count == '0) status <= ST_EMPTY;
              else if ((fn == FN_DEL_AT || fn == FN_GET || fn == FN_SET)
                       && pos >= count) status <= ST_BADIDX;
              else if (fn == FN_SET) begin
                we <= 1'b1; waddr <= tgt; wdata <= val;
              end else begin
                grab <= 1'b1;
                state <= S_RDW;
                if (fn == FN_DEL_FRST) cur <= start_pos;
                else if (fn == FN_DEL_LAST) cur <= endp[AddrW-1:0] - 1'b1;
                else cur <= tgt;
                if (fn != FN_GET) begin
                  count <= count - 1'b1;
                  if (count == cnt_t'(1)) start_pos <= '0;
                  else if (fn == FN_DEL_FRST) start_pos <= start_pos + 1'b1;
                end
              end
            end
            FN_SEARCH: begin
              status <= ST_NOTFOUND;
              sidx <= '0;
              srch_pend <= 1'b0;
              if (count != '0) state <= S_SRCH;
            end
            default: ;
          endcase
        end
        S_RDW: begin
          // rdata valid next cycle
          state <= S_MVRD;
          grab  <= 1'b1;
        end
        S_MVRD: begin
          if (grab) begin
            grab <= 1'b0;
            read_value <= rdata;
            // delete at: then walk tgt+1..last leftward
            if (fn == FN_DEL_AT && pos != count) begin
              dir_r <= 1'b0; cur <= cur + 1'b1;
              stop <= endp[AddrW-1:0];
              state <= S_MVRD;
            end else state <= S_OUT;
          end else state <= S_MVWR;
        end
        S_MVWR: begin
          we    <= 1'b1;
          wdata <= rdata;
          waddr <= dir_r ? cur + 1'b1 : cur - 1'b1;
          if (cur == stop) begin
            state <= S_OUT;
          end else begin
            cur   <= dir_r ? cur - 1'b1 : cur + 1'b1;
            state <= S_MVRD;
          end
        end
        S_SRCH: begin
          if (srch_pend && rdata == val) begin
            status      <= ST_OK;
            found_index <= 6'(sidx - 1'b1);
            state       <= S_OUT;
          end else if (sidx == count) begin
            state <= S_OUT;
          end else begin
            sidx      <= sidx + 1'b1;
            srch_pend <= 1'b1;
          end
        end
        S_OUT: begin
          if (fin_wr) begin
            fin_wr <= 1'b0;
            we <= 1'b1; waddr <= fin_addr; wdata <= val;
          end else if (!out_valid) begin
            out_valid <= 1'b1;
            length    <= 7'(count);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) count <= cnt_t'(Depth))
    else $error("count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_len: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (length == 7'(count))) else $error("length mismatch");
`endif
endmodule
`default_nettype wire
